### design/txtpx_pkg.sv
// Package for the 5x7 text pixel generator: job type, font table and
// character decode. No dependencies; used by the front, queue, back end and top.
package txtpx_pkg;

    localparam int CHAR_PITCH  = 6;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;
    localparam int X_MAX       = 511;

    localparam logic [7:0] CODE_UPPER_A = 8'h41;
    localparam logic [7:0] CODE_UPPER_Z = 8'h5A;
    localparam logic [7:0] CODE_LOWER_A = 8'h61;
    localparam logic [7:0] CODE_LOWER_Z = 8'h7A;
    localparam logic [7:0] CODE_DIGIT_0 = 8'h30;
    localparam logic [7:0] CODE_DIGIT_9 = 8'h39;
    localparam logic [5:0] DIGIT_BASE   = 6'd26;

    // One glyph: bit (col*7 + row), column 0 / row 0 in bit 0.
    typedef logic [GLYPH_BITS-1:0] glyph_t;

    typedef struct packed {
        glyph_t     bits;
        logic [8:0] x;
        logic [6:0] y;
        logic       value;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Glyph decode: valid flag plus index 0..35.
    typedef struct packed {
        logic       hit;
        logic [5:0] idx;
    } gsel_t;

    function automatic gsel_t glyph_select(input logic [7:0] ch);
        gsel_t g;
        g.hit = 1'b1;
        g.idx = '0;
        if (ch >= CODE_UPPER_A && ch <= CODE_UPPER_Z) begin
            g.idx = 6'(ch - CODE_UPPER_A);
        end else if (ch >= CODE_LOWER_A && ch <= CODE_LOWER_Z) begin
            g.idx = 6'(ch - CODE_LOWER_A);
        end else if (ch >= CODE_DIGIT_0 && ch <= CODE_DIGIT_9) begin
            g.idx = DIGIT_BASE + 6'(ch - CODE_DIGIT_0);
        end else begin
            g.hit = 1'b0;
        end
        return g;
    endfunction

    // Font columns, written col4..col0 so column 0 lands in the low bits.
    function automatic glyph_t glyph_rom(input logic [5:0] idx);
        glyph_t r;
        case (idx)
            6'd0:    r = {7'h00, 7'h7E, 7'h11, 7'h11, 7'h7E};
            6'd1:    r = {7'h00, 7'h36, 7'h49, 7'h49, 7'h7F};
            6'd2:    r = {7'h00, 7'h22, 7'h41, 7'h41, 7'h3E};
            6'd3:    r = {7'h00, 7'h3E, 7'h41, 7'h41, 7'h7F};
            6'd4:    r = {7'h00, 7'h41, 7'h49, 7'h49, 7'h7F};
            6'd5:    r = {7'h00, 7'h01, 7'h09, 7'h09, 7'h7F};
            6'd6:    r = {7'h00, 7'h32, 7'h51, 7'h41, 7'h3E};
            6'd7:    r = {7'h00, 7'h7F, 7'h08, 7'h08, 7'h7F};
            6'd8:    r = {7'h00, 7'h00, 7'h41, 7'h7F, 7'h41};
            6'd9:    r = {7'h00, 7'h3F, 7'h41, 7'h40, 7'h20};
            6'd10:   r = {7'h00, 7'h63, 7'h14, 7'h08, 7'h7F};
            6'd11:   r = {7'h00, 7'h40, 7'h40, 7'h40, 7'h7F};
            6'd12:   r = {7'h7F, 7'h02, 7'h04, 7'h02, 7'h7F};
            6'd13:   r = {7'h00, 7'h7F, 7'h08, 7'h04, 7'h7F};
            6'd14:   r = {7'h00, 7'h3E, 7'h41, 7'h41, 7'h3E};
            6'd15:   r = {7'h00, 7'h06, 7'h09, 7'h09, 7'h7F};
            6'd16:   r = {7'h00, 7'h3E, 7'h61, 7'h41, 7'h3E};
            6'd17:   r = {7'h00, 7'h66, 7'h19, 7'h09, 7'h7F};
            6'd18:   r = {7'h00, 7'h32, 7'h49, 7'h49, 7'h26};
            6'd19:   r = {7'h00, 7'h01, 7'h01, 7'h7F, 7'h01};
            6'd20:   r = {7'h00, 7'h3F, 7'h40, 7'h40, 7'h3F};
            6'd21:   r = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
            6'd22:   r = {7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F};
            6'd23:   r = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
            6'd24:   r = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
            6'd25:   r = {7'h43, 7'h45, 7'h49, 7'h51, 7'h61};
            6'd26:   r = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
            6'd27:   r = {7'h00, 7'h40, 7'h7F, 7'h42, 7'h00};
            6'd28:   r = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
            6'd29:   r = {7'h36, 7'h49, 7'h49, 7'h41, 7'h22};
            6'd30:   r = {7'h10, 7'h7F, 7'h12, 7'h14, 7'h18};
            6'd31:   r = {7'h31, 7'h49, 7'h49, 7'h49, 7'h2F};
            6'd32:   r = {7'h30, 7'h49, 7'h49, 7'h49, 7'h3E};
            6'd33:   r = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
            6'd34:   r = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
            6'd35:   r = {7'h3E, 7'h49, 7'h49, 7'h49, 7'h06};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### design/txtpx_front.sv
// Front end: takes character transactions, keeps the cursor, looks up and
// edge-clips the glyph, and queues a drawing job. Depends on txtpx_pkg.
module txtpx_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        character,
    input  logic              new_string,
    input  logic [8:0]        start_x,
    input  logic [6:0]        start_y,
    input  logic              pixel_on,
    input  logic              q_full,
    output logic              push,
    output txtpx_pkg::job_t   push_job
);
    import txtpx_pkg::*;

    logic [8:0] cursor_x_reg, cursor_x_next;
    logic [6:0] cursor_y_reg, cursor_y_next;
    logic [8:0] eff_x;
    logic [6:0] eff_y;
    logic [9:0] adv_sum;
    gsel_t      gsel;
    glyph_t     clipped;
    logic       take;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    assign eff_x = new_string ? start_x : cursor_x_reg;
    assign eff_y = new_string ? start_y : cursor_y_reg;
    assign gsel  = glyph_select(character);

    // Drop columns that would fall past the right edge.
    always_comb begin
        clipped = gsel.hit ? glyph_rom(gsel.idx) : '0;
        for (int c = 0; c < GLYPH_COLS; c++) begin
            if (eff_x > 9'(X_MAX - c)) begin
                clipped[c*GLYPH_ROWS +: GLYPH_ROWS] = '0;
            end
        end
    end

    assign push           = take && (clipped != '0);
    assign push_job.bits  = clipped;
    assign push_job.x     = eff_x;
    assign push_job.y     = eff_y;
    assign push_job.value = pixel_on;

    assign adv_sum = {1'b0, eff_x} + 10'(CHAR_PITCH);

    always_comb begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (take) begin
            cursor_x_next = (adv_sum > 10'(X_MAX)) ? 9'(X_MAX) : adv_sum[8:0];
            cursor_y_next = eff_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end else begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

endmodule

### design/txtpx_fifo.sv
// Two-entry job queue between front and back end.
// Depends on txtpx_pkg.
module txtpx_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  txtpx_pkg::job_t       push_job,
    input  logic                  pop,
    output txtpx_pkg::job_t       pop_job,
    output txtpx_pkg::q_status_t  status
);
    import txtpx_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_job      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/txtpx_back.sv
// Back end: walks one glyph position per cycle, stalling on a lit one while
// the output register is held; pixels leave through it. Depends on txtpx_pkg.
module txtpx_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  txtpx_pkg::job_t       pop_job,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [8:0]            plot_x,
    output logic [7:0]            plot_y,
    output logic                  plot_value,
    output logic                  last_pixel
);
    import txtpx_pkg::*;

    logic       busy_reg, busy_next;
    glyph_t     bits_reg, bits_next;
    logic [2:0] col_reg, col_next;
    logic [2:0] row_reg, row_next;
    logic [8:0] base_x_reg;
    logic [6:0] base_y_reg;
    logic       value_reg;

    logic       ovalid_reg, ovalid_next;
    logic [8:0] ox_reg;
    logic [7:0] oy_reg;
    logic       oval_reg;
    logic       olast_reg;

    logic       out_free;
    logic       advance;
    logic       emit;

    assign out_free = !ovalid_reg || out_ready;
    assign advance  = busy_reg && (!bits_reg[0] || out_free);
    assign emit     = advance && bits_reg[0];
    assign pop      = !busy_reg && !q_empty;

    always_comb begin
        busy_next = busy_reg;
        bits_next = bits_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (pop) begin
            busy_next = 1'b1;
            bits_next = pop_job.bits;
            col_next  = '0;
            row_next  = '0;
        end else if (advance) begin
            bits_next = bits_reg >> 1;
            busy_next = (bits_reg[GLYPH_BITS-1:1] != '0);
            if (row_reg == 3'(GLYPH_ROWS - 1)) begin
                row_next = '0;
                col_next = col_reg + 3'd1;
            end else begin
                row_next = row_reg + 3'd1;
            end
        end
    end

    always_comb begin
        ovalid_next = ovalid_reg;
        if (emit) begin
            ovalid_next = 1'b1;
        end else if (out_ready) begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg <= bits_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        if (pop) begin
            base_x_reg <= pop_job.x;
            base_y_reg <= pop_job.y;
            value_reg  <= pop_job.value;
        end
        if (emit) begin
            ox_reg    <= base_x_reg + 9'(col_reg);
            oy_reg    <= {1'b0, base_y_reg} + 8'(row_reg);
            oval_reg  <= value_reg;
            olast_reg <= (bits_reg[GLYPH_BITS-1:1] == '0);
        end
    end

    assign out_valid  = ovalid_reg;
    assign plot_x     = ox_reg;
    assign plot_y     = oy_reg;
    assign plot_value = oval_reg;
    assign last_pixel = olast_reg;

endmodule

### design/ascii_5x7_text_pixel_generator.sv
// 5x7 text pixel generator, top level. A character passes the queue entry,
// the back end's glyph register and the output register before its first
// pixel is valid, after the unlit positions ahead of its first lit one are
// walked. The back end walks one glyph position per cycle unless a lit one
// waits on a stalled output; a character holds it for a load step and its
// positions up to its last lit one. Blank or clipped-away ones draw nothing.
// Reset (aresetn low, synchronous) clears cursor, queue and output valid.
module ascii_5x7_text_pixel_generator (
    input  logic        aclk,
    input  logic        aresetn,
    // character transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // character[7:0], start_x[16:8], start_y[23:17], pixel_on[24]
    input  logic        s_tuser,  // new_string
    // pixel plot transactions
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // plot_x[8:0], plot_y[16:9], plot_value[17]
    output logic        m_tlast   // last_pixel
);
    import txtpx_pkg::*;

    // front end -> queue
    logic       push;
    job_t       push_job;
    // queue -> back end
    logic       pop;
    job_t       pop_job;
    q_status_t  q_status;

    logic [8:0] plot_x;
    logic [7:0] plot_y;
    logic       plot_value;

    // Front end: cursor tracking, font lookup, right-edge clipping.
    // Accepts whenever the queue has room, so a whole string of blank
    // characters streams through at one per cycle.
    txtpx_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .character  (s_tdata[7:0]),
        .new_string (s_tuser),
        .start_x    (s_tdata[16:8]),
        .start_y    (s_tdata[23:17]),
        .pixel_on   (s_tdata[24]),
        .q_full     (q_status.full),
        .push       (push),
        .push_job   (push_job)
    );

    // Two jobs of slack between the sides.
    txtpx_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    // Back end: scans columns then rows, one glyph bit a cycle, stalls on
    // a lit bit while the output register is still held.
    txtpx_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_status.empty),
        .pop_job    (pop_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .plot_x     (plot_x),
        .plot_y     (plot_y),
        .plot_value (plot_value),
        .last_pixel (m_tlast)
    );

    assign m_tdata = {6'b0, plot_value, plot_y, plot_x};

endmodule

### design/txtpx_checker.sv
// Port-level checks for the 5x7 text pixel generator, bound to the top.
// Depends on the top level's ports only.
module txtpx_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // Stalled pixel holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("pixel transaction changed while stalled");

    // Nothing comes out straight after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // Row never goes below the lowest start row plus six.
    a_yrange: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[16:9] <= 8'd133)
        else $error("plot_y out of range");

    // Padding bits stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:18] == 6'd0)
        else $error("tdata padding not zero");

endmodule

bind ascii_5x7_text_pixel_generator txtpx_checker u_txtpx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
